// File: rtl/utf8_stream_decoder_assert.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Expects signals clk and arst_n in the including module's scope.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Check a condition at every clock edge once out of reset.
`define U8D_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define U8D_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 stream decoder: types, error codes, lead byte tables.
// No dependencies.
package u8d_pkg;

	localparam int unsigned CpW  = 31;
	localparam int unsigned LenW = 3;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_STRAY  = 2'd1,
		ERR_BROKEN = 2'd2
	} err_kind_t;

	typedef struct packed {
		logic [CpW-1:0]  acc;
		logic [LenW-1:0] pend;
		logic [LenW-1:0] len;
	} dec_state_t;

	typedef struct packed {
		logic            emit;
		logic [CpW-1:0]  cp;
		logic [LenW-1:0] nbytes;
		err_kind_t       err;
	} dec_result_t;

	// Sequence length from a lead byte; zero for a continuation byte.
	function automatic logic [LenW-1:0] lead_length(input logic [7:0] b);
		logic [LenW-1:0] n;
		case (b) inside
			[8'h00:8'h7F]: n = 3'd1;
			[8'h80:8'hBF]: n = 3'd0;
			[8'hC0:8'hDF]: n = 3'd2;
			[8'hE0:8'hEF]: n = 3'd3;
			[8'hF0:8'hF7]: n = 3'd4;
			[8'hF8:8'hFB]: n = 3'd5;
			default:       n = 3'd6;
		endcase
		return n;
	endfunction

	// Payload mask of a lead byte for a given sequence length.
	function automatic logic [7:0] lead_mask(input logic [LenW-1:0] n);
		logic [7:0] m;
		case (n)
			3'd1:    m = 8'h7F;
			3'd2:    m = 8'h1F;
			3'd3:    m = 8'h0F;
			3'd4:    m = 8'h07;
			3'd5:    m = 8'h03;
			default: m = 8'h01;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/u8d_step.sv
`timescale 1ns / 1ps
// Combinational per-byte update of the UTF-8 decoder state and result.
// Depends on u8d_pkg.
module u8d_step (
	input  logic [7:0]           byte_in,
	input  u8d_pkg::dec_state_t  cur,
	output u8d_pkg::dec_state_t  nxt,
	output u8d_pkg::dec_result_t res
);
	import u8d_pkg::*;

	logic            is_cont;
	logic [LenW-1:0] lead_len;
	logic [7:0]      lead_bits;
	logic [CpW-1:0]  acc_shift;
	logic [LenW-1:0] pend_dec;

	assign is_cont   = (byte_in[7:6] == 2'b10);
	assign lead_len  = lead_length(byte_in);
	assign lead_bits = byte_in & lead_mask(lead_len);
	assign acc_shift = {cur.acc[CpW-7:0], byte_in[5:0]};
	assign pend_dec  = cur.pend - 3'd1;

	always_comb begin
		nxt        = cur;
		res.emit   = 1'b0;
		res.cp     = '0;
		res.nbytes = '0;
		res.err    = ERR_OK;
		if (cur.pend == '0) begin
			if (lead_len == '0) begin
				// stray continuation: report, stay idle
				res.emit = 1'b1;
				res.err  = ERR_STRAY;
			end else if (lead_len == 3'd1) begin
				res.emit   = 1'b1;
				res.cp     = {{(CpW-8){1'b0}}, lead_bits};
				res.nbytes = 3'd1;
				nxt.acc    = '0;
				nxt.len    = '0;
			end else begin
				nxt.acc  = {{(CpW-8){1'b0}}, lead_bits};
				nxt.len  = lead_len;
				nxt.pend = lead_len - 3'd1;
			end
		end else if (!is_cont) begin
			// drop the byte and close the sequence
			res.emit = 1'b1;
			res.err  = ERR_BROKEN;
			nxt.acc  = '0;
			nxt.pend = '0;
			nxt.len  = '0;
		end else if (pend_dec != '0) begin
			nxt.acc  = acc_shift;
			nxt.pend = pend_dec;
		end else begin
			res.emit   = 1'b1;
			res.cp     = acc_shift;
			res.nbytes = cur.len;
			nxt.acc    = '0;
			nxt.pend   = '0;
			nxt.len    = '0;
		end
	end

endmodule

// File: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 stream decoder: input register, decode, result register.
// Depends on u8d_pkg, u8d_step and utf8_stream_decoder_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_ready  | in_byte
//  result  | out_valid/ out_ready | code_point, seq_bytes, error_kind
//
// One byte is taken every cycle unless the held byte emits while a result is
// stalled; a byte is held in the input register, its result in the result register.
// The decode sits between the input register and the result register.
// Reset returns to idle with no sequence open and both registers empty.
// A stalled result holds in the result register; bytes that give no result
// still drain, so only a byte that emits waits behind a stalled result.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [30:0] code_point,
	output logic [2:0]  seq_bytes,
	output logic [1:0]  error_kind,
	output logic        out_valid,
	input  logic        out_ready
);
	import u8d_pkg::*;

	// input register
	logic [7:0]      byte_s1;
	logic            vld_s1;
	// decoder state
	dec_state_t      state_q;
	dec_state_t      state_nxt;
	dec_result_t     res;
	// result register
	logic            vld_s2;
	logic [CpW-1:0]  cp_s2;
	logic [LenW-1:0] nbytes_s2;
	err_kind_t       err_s2;

	logic out_free;
	logic adv_s1;
	logic in_take;
	logic err_out;
	logic ok_out;

	u8d_step u_step (
		.byte_in (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Advance the held byte when it emits nothing or the result slot frees up.
	assign out_free = !vld_s2 || out_ready;
	assign adv_s1   = vld_s1 && (!res.emit || out_free);
	assign in_ready = !vld_s1 || adv_s1;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			state_q <= '0;
		end else begin
			if (in_take) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1 && res.emit) begin
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: load on handshake, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
		if (adv_s1 && res.emit) begin
			cp_s2     <= res.cp;
			nbytes_s2 <= res.nbytes;
			err_s2    <= res.err;
		end
	end

	assign out_valid  = vld_s2;
	assign code_point = cp_s2;
	assign seq_bytes  = nbytes_s2;
	assign error_kind = err_s2;

	// Result classes seen by the checks below.
	assign err_out = vld_s2 && (err_s2 != ERR_OK);
	assign ok_out  = vld_s2 && (err_s2 == ERR_OK);

	`include "utf8_stream_decoder_assert.svh"

	`U8D_ASSERT_IMPLY(a_err_zero, err_out, cp_s2 == '0 && nbytes_s2 == '0, "error with payload")
	`U8D_ASSERT_IMPLY(a_ok_len, ok_out, nbytes_s2 != '0, "decoded result with zero byte count")
	`U8D_ASSERT_IMPLY(a_pend_len, state_q.pend != '0, state_q.len > state_q.pend, "pending too large")
	`U8D_ASSERT_ALWAYS(a_pend_max, state_q.pend <= 3'd5, "pending count beyond six-byte form")

endmodule
